@@ src/wblc_pkg.sv @@
// Package for the write-back LRU cache: geometry constants, command codes
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none
package wblc_pkg;
	localparam int NUM_SETS  = 16;
	localparam int LINE_SIZE = 64;
	localparam int NUM_WAYS  = 4;
	localparam int MEM_SIZE  = 65536;

	localparam int OFF_W   = $clog2(LINE_SIZE);
	localparam int SET_W   = $clog2(NUM_SETS);
	localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int ADDR_W  = $clog2(MEM_SIZE);
	localparam int TAG_W   = ADDR_W - OFF_W - SET_W;
	localparam int LINES   = NUM_SETS * NUM_WAYS;
	localparam int LINE_W  = $clog2(LINES);
	localparam int STORE_W = $clog2(LINES * LINE_SIZE);

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic load;      // capture input item
		logic lookup;    // register tag compare and victim choice
		logic wb_step;   // move one byte from line to memory
		logic fill_step; // move one byte from memory to line
		logic install;   // write tag, valid, clean; count miss, advance stamp
		logic rd_step;   // read the addressed byte of the line
		logic finish;    // perform byte access, stamps, result register
		logic clr_step;  // clear one memory word
		logic div_start; // start miss-rate division
		logic div_step;  // one quotient bit
		logic q_finish;  // query result register
	} ctl_t;

	typedef struct packed {
		logic hit;
		logic victim_dirty;
		logic byte_last;  // byte counter past final offset
		logic clr_last;   // clearing pass past final address
		logic div_last;   // final quotient bit
	} sts_t;
endpackage
`default_nettype wire

@@ src/write_back_lru_cache_top.sv @@
// Top level of the write-back LRU cache: joins controller and datapath.
// Depends on wblc_pkg, wblc_ctrl, wblc_datapath.
//
//  channel  signals                                    dir
//  input    in_valid, in_stall, command/address/write_data   in
//  output   out_valid, out_stall, read_data/was_hit/miss_rate_percent out
//
// Accept to result: a miss first writes back a dirty victim, then fills the
// line, one byte per cycle through the line store port, before the byte access.
// Query: one quotient bit per cycle in the divider; an unknown command skips it.
// After reset the backing memory is cleared; no item is taken until then.
// A stalled result holds; the next item waits until the result is taken.
`default_nettype none
module write_back_lru_cache_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  write_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       read_data,
	output logic             was_hit,
	output logic [6:0]       miss_rate_percent
);
	import wblc_pkg::*;

	ctl_t ctl;
	sts_t sts;

	wblc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .command,
		.out_valid, .out_stall, .ctl, .sts
	);

	wblc_datapath u_dp (
		.clk, .arst_n, .ctl, .sts, .command, .address, .write_data,
		.read_data_q(read_data), .was_hit_q(was_hit), .rate_q(miss_rate_percent)
	);
endmodule
`default_nettype wire

@@ src/wblc_datapath.sv @@
// Datapath of the write-back LRU cache: line store, backing memory, tags,
// use stamps, counters and a bit-serial divider for the miss rate.
// Depends on wblc_pkg.
`default_nettype none
module wblc_datapath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire wblc_pkg::ctl_t            ctl,
	output wblc_pkg::sts_t                 sts,
	input  wire logic [1:0]                command,
	input  wire logic [15:0]               address,
	input  wire logic [7:0]                write_data,
	output logic [7:0]                     read_data_q,
	output logic                           was_hit_q,
	output logic [6:0]                     rate_q
);
	import wblc_pkg::*;

	logic [1:0]          cmd_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [7:0]          wdata_q;
	logic [TAG_W-1:0]    tag_mem_q [NUM_WAYS][NUM_SETS];
	logic [LINES-1:0]    valid_q, dirty_q;
	logic [31:0]         stamp_q [NUM_WAYS][NUM_SETS];
	logic [31:0]         use_q, acc_q, miss_q;
	logic [7:0]          line_mem [LINES*LINE_SIZE];
	logic [7:0]          back_mem [MEM_SIZE];
	logic                hit_q, vdirty_q;
	logic [WAY_W-1:0]    way_q;
	logic [TAG_W-1:0]    vtag_q;
	logic [OFF_W:0]      cnt_q;
	logic [ADDR_W:0]     clr_q;
	logic [7:0]          rdata_s1;
	logic [7:0]          bdata_s1;
	logic                wb_pend_q, fill_pend_q;
	logic [OFF_W-1:0]    wb_off_q, fill_off_q;
	logic [39:0]         rem_q;
	logic [39:0]         dvd_q;
	logic [31:0]         dvs_q;
	logic [6:0]          quo_q;
	logic                quo_ovf_q;
	logic [5:0]          dbit_q;

	logic [TAG_W-1:0]    tag_w;
	logic [SET_W-1:0]    set_w;
	logic [OFF_W-1:0]    off_w;
	logic                hit_w, inv_w;
	logic [WAY_W-1:0]    hway_w, iway_w, lway_w, way_w;
	logic [31:0]         best_age_w, age_w;
	logic [LINE_W-1:0]   line_w;
	logic [STORE_W-1:0]  lpos_w;
	logic [ADDR_W-1:0]   fill_addr_w;
	logic [40:0]         sub_w;
	logic [47:0]         miss100_w;

	assign tag_w = addr_q[ADDR_W-1 -: TAG_W];
	assign set_w = addr_q[OFF_W +: SET_W];
	assign off_w = addr_q[OFF_W-1:0];
	assign line_w = LINE_W'({set_w, way_q}) ;

	always_comb begin
		hit_w = 1'b0;
		inv_w = 1'b0;
		hway_w = '0;
		iway_w = '0;
		lway_w = '0;
		best_age_w = '0;
		age_w = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (valid_q[{set_w, WAY_W'(w)}] && tag_mem_q[WAY_W'(w)][set_w] == tag_w) begin
				hit_w = 1'b1;
				hway_w = WAY_W'(w);
			end
			if (!valid_q[{set_w, WAY_W'(w)}]) begin
				inv_w = 1'b1;
				iway_w = WAY_W'(w);
			end
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			age_w = use_q + 32'd1 - stamp_q[WAY_W'(w)][set_w];
			if (w == 0 || age_w > best_age_w) begin
				best_age_w = age_w;
				lway_w = WAY_W'(w);
			end
		end
		way_w = hit_w ? hway_w : (inv_w ? iway_w : lway_w);
	end

	assign lpos_w = {line_w, cnt_q[OFF_W-1:0]};
	assign fill_addr_w = {tag_w, set_w, cnt_q[OFF_W-1:0]};

	assign sts.hit = hit_q;
	assign sts.victim_dirty = vdirty_q;
	assign sts.byte_last = (cnt_q == (OFF_W+1)'(LINE_SIZE));
	assign sts.clr_last = clr_q[ADDR_W];
	assign sts.div_last = (dbit_q == 6'd0);

	assign miss100_w = {16'd0, miss_q} * 48'd100;
	assign sub_w = {rem_q, dvd_q[39]} - {9'd0, dvs_q};

	// memories: one write port, registered reads
	always_ff @(posedge clk) begin
		if (ctl.clr_step)
			back_mem[clr_q[ADDR_W-1:0]] <= 8'd0;
		else if (wb_pend_q)
			back_mem[{vtag_q, set_w, wb_off_q}] <= rdata_s1;
		if (ctl.fill_step)
			bdata_s1 <= back_mem[fill_addr_w];
	end

	always_ff @(posedge clk) begin
		if (fill_pend_q)
			line_mem[{line_w, fill_off_q}] <= bdata_s1;
		else if (ctl.finish && cmd_q == CMD_WRITE)
			line_mem[{line_w, off_w}] <= wdata_q;
		if (ctl.wb_step)
			rdata_s1 <= line_mem[lpos_w];
		else if (ctl.rd_step)
			rdata_s1 <= line_mem[{line_w, off_w}];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command;
			addr_q <= address[ADDR_W-1:0];
			wdata_q <= write_data;
		end
		if (ctl.lookup) begin
			hit_q <= hit_w;
			way_q <= way_w;
			vtag_q <= tag_mem_q[way_w][set_w];
			vdirty_q <= valid_q[{set_w, way_w}] && dirty_q[{set_w, way_w}];
		end
		if (ctl.wb_step)
			wb_off_q <= cnt_q[OFF_W-1:0];
		if (ctl.fill_step)
			fill_off_q <= cnt_q[OFF_W-1:0];
		if (ctl.div_start) begin
			dvd_q <= miss100_w[39:0];
			dvs_q <= acc_q;
			rem_q <= '0;
			quo_q <= '0;
			quo_ovf_q <= 1'b0;
		end else if (ctl.div_step) begin
			if (quo_q[6])
				quo_ovf_q <= 1'b1;
			if (!sub_w[40]) begin
				rem_q <= sub_w[39:0];
				quo_q <= {quo_q[5:0], 1'b1};
			end else begin
				rem_q <= {rem_q[38:0], dvd_q[39]};
				quo_q <= {quo_q[5:0], 1'b0};
			end
			dvd_q <= {dvd_q[38:0], 1'b0};
		end
		if (ctl.finish || ctl.q_finish) begin
			read_data_q <= (ctl.finish && cmd_q == CMD_READ) ? rdata_s1 : 8'd0;
			was_hit_q <= ctl.finish && hit_q;
			rate_q <= '0;
			if (ctl.q_finish && cmd_q == CMD_QUERY && acc_q != 32'd0)
				rate_q <= (quo_ovf_q || quo_q > 7'd100) ? 7'd100 : quo_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			use_q <= '0;
			acc_q <= '0;
			miss_q <= '0;
			cnt_q <= '0;
			clr_q <= '0;
			wb_pend_q <= 1'b0;
			fill_pend_q <= 1'b0;
			dbit_q <= '0;
			for (int w = 0; w < NUM_WAYS; w++) begin
				for (int s = 0; s < NUM_SETS; s++) begin
					tag_mem_q[w][s] <= '0;
					stamp_q[w][s] <= '0;
				end
			end
		end else begin
			wb_pend_q <= ctl.wb_step;
			fill_pend_q <= ctl.fill_step;
			if (ctl.clr_step)
				clr_q <= clr_q + (ADDR_W+1)'(1);
			if (ctl.lookup || ctl.install || ctl.finish)
				cnt_q <= '0;
			else if (ctl.wb_step || ctl.fill_step)
				cnt_q <= cnt_q + (OFF_W+1)'(1);
			if (ctl.div_start)
				dbit_q <= 6'd39;
			else if (ctl.div_step && dbit_q != 6'd0)
				dbit_q <= dbit_q - 6'd1;
			if (ctl.install) begin
				tag_mem_q[way_q][set_w] <= tag_w;
				valid_q[line_w] <= 1'b1;
				dirty_q[line_w] <= 1'b0;
				miss_q <= miss_q + 32'd1;
				use_q <= use_q + 32'd1;
			end
			if (ctl.lookup && (cmd_q == CMD_READ || cmd_q == CMD_WRITE)) begin
				use_q <= use_q + 32'd1;
				acc_q <= acc_q + 32'd1;
			end
			if (ctl.finish) begin
				stamp_q[way_q][set_w] <= use_q;
				if (cmd_q == CMD_WRITE)
					dirty_q[line_w] <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ src/wblc_ctrl.sv @@
// Controller of the write-back LRU cache: sequences reset clearing, lookup,
// write-back, fill, byte access and the miss-rate division.
// Depends on wblc_pkg.
`default_nettype none
module wblc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        command,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output wblc_pkg::ctl_t         ctl,
	input  wire wblc_pkg::sts_t    sts
);
	import wblc_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LOOK, S_DECIDE, S_WB, S_WBD, S_FILL, S_FILLD,
		S_INST, S_RD, S_FIN, S_DIV, S_QFIN
	} state_t;

	state_t state_q;
	logic   take_w;
	logic   res_w;

	assign take_w = in_valid && !in_stall;
	// output register is free once taken or empty
	assign in_stall = (state_q != S_IDLE) || (out_valid && out_stall);
	assign res_w = ctl.finish || ctl.q_finish;

	always_comb begin
		ctl = '0;
		ctl.load = take_w;
		case (state_q)
			S_CLEAR:  ctl.clr_step = 1'b1;
			S_LOOK:   ctl.lookup = 1'b1;
			S_WB:     ctl.wb_step = !sts.byte_last;
			S_FILL:   ctl.fill_step = !sts.byte_last;
			S_INST:   ctl.install = 1'b1;
			S_RD:     ctl.rd_step = 1'b1;
			S_FIN:    ctl.finish = !(out_valid && out_stall);
			S_DIV:    ctl.div_step = 1'b1;
			S_QFIN:   ctl.q_finish = !(out_valid && out_stall);
			default:  ctl.div_start = 1'b0;
		endcase
		if (take_w && command == CMD_QUERY)
			ctl.div_start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			if (res_w)
				out_valid <= 1'b1;
			case (state_q)
				S_CLEAR:  if (sts.clr_last) state_q <= S_IDLE;
				S_IDLE:   if (take_w)
						state_q <= (command == CMD_QUERY) ? S_DIV :
							(command == CMD_NONE) ? S_QFIN : S_LOOK;
				S_LOOK:   state_q <= S_DECIDE;
				S_DECIDE: if (sts.hit) state_q <= S_RD;
					else if (sts.victim_dirty) state_q <= S_WB;
					else state_q <= S_INST;
				S_WB:     if (sts.byte_last) state_q <= S_WBD;
				S_WBD:    state_q <= S_INST;
				S_INST:   state_q <= S_FILL;
				S_FILL:   if (sts.byte_last) state_q <= S_FILLD;
				S_FILLD:  state_q <= S_RD;
				S_RD:     state_q <= S_FIN;
				S_FIN:    if (ctl.finish) state_q <= S_IDLE;
				S_DIV:    if (sts.div_last) state_q <= S_QFIN;
				S_QFIN:   if (ctl.q_finish) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ src/wblc_checker.sv @@
// Port checker for the write-back LRU cache, bound to the top level.
// Depends on write_back_lru_cache_top ports only.
`default_nettype none
module wblc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] read_data,
	input wire logic       was_hit,
	input wire logic [6:0] miss_rate_percent
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data))
		else $error("result dropped while stalled");
	a_rate_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> miss_rate_percent <= 7'd100)
		else $error("rate above 100");
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && miss_rate_percent != 7'd0 |-> !was_hit && read_data == 8'd0)
		else $error("query result mixed with access");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken at once");
endmodule

bind write_back_lru_cache_top wblc_checker u_chk (.*);
`default_nettype wire

@@ tb/write_back_lru_cache_top_test.sv @@
// Testbench for write_back_lru_cache_top: drives read, write, miss-rate query
// and unknown-command items and checks every result against a cache model held here.
// Depends on wblc_pkg and write_back_lru_cache_top.
`timescale 1ns / 100ps
`default_nettype none
module write_back_lru_cache_top_test;
	import wblc_pkg::*;

	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] addr;
		logic [7:0]  data;
	} access_t;

	typedef struct packed {
		logic [7:0] rd;
		logic       hit;
		logic [6:0] rate;
	} answer_t;

	localparam int WATCHDOG_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  read_data;
	logic        was_hit;
	logic [6:0]  miss_rate_percent;

	write_back_lru_cache_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .address(address), .write_data(write_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_data(read_data), .was_hit(was_hit),
		.miss_rate_percent(miss_rate_percent)
	);

	// cache model
	logic [7:0]  mem_image [MEM_SIZE];
	logic [7:0]  line_bytes [LINES][LINE_SIZE];
	logic [5:0]  way_tag [LINES];
	logic        way_valid [LINES];
	logic        way_dirty [LINES];
	logic [31:0] way_stamp [LINES];
	logic [31:0] stamp_count;
	logic [31:0] access_total;
	logic [31:0] miss_total;

	access_t pending_items [$];
	answer_t expected_answers [$];
	logic    stimulus_done;
	logic    failed;
	logic    idle_free;
	int      watchdog;

	function automatic answer_t cache_access(access_t it);
		answer_t     r;
		logic [5:0]  tg;
		logic [3:0]  st;
		int          ln;
		int          vw;
		logic        found;
		logic [31:0] age;
		logic [31:0] best_age;
		r = '0;
		if (it.cmd == CMD_READ || it.cmd == CMD_WRITE) begin
			tg = it.addr[15:10];
			st = it.addr[9:6];
			found = 1'b0;
			ln = 0;
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (!found && way_valid[st*NUM_WAYS+w] && way_tag[st*NUM_WAYS+w] == tg) begin
					found = 1'b1;
					ln = st*NUM_WAYS + w;
				end
			end
			stamp_count++;
			access_total++;
			if (!found) begin
				miss_total++;
				vw = -1;
				for (int w = 0; w < NUM_WAYS; w++)
					if (vw < 0 && !way_valid[st*NUM_WAYS+w])
						vw = w;
				if (vw < 0) begin
					best_age = 0;
					for (int w = 0; w < NUM_WAYS; w++) begin
						age = stamp_count - way_stamp[st*NUM_WAYS+w];
						if (w == 0 || age > best_age) begin
							vw = w;
							best_age = age;
						end
					end
				end
				ln = st*NUM_WAYS + vw;
				if (way_valid[ln] && way_dirty[ln])
					for (int i = 0; i < LINE_SIZE; i++)
						mem_image[{way_tag[ln], st, 6'(i)}] = line_bytes[ln][i];
				way_tag[ln] = tg;
				way_valid[ln] = 1'b1;
				way_dirty[ln] = 1'b0;
				stamp_count++;
				for (int i = 0; i < LINE_SIZE; i++)
					line_bytes[ln][i] = mem_image[{tg, st, 6'(i)}];
			end
			way_stamp[ln] = stamp_count;
			if (it.cmd == CMD_READ)
				r.rd = line_bytes[ln][it.addr[5:0]];
			else begin
				line_bytes[ln][it.addr[5:0]] = it.data;
				way_dirty[ln] = 1'b1;
			end
			r.hit = found;
		end else if (it.cmd == CMD_QUERY && access_total != 0) begin
			r.rate = 7'((64'(miss_total) * 100) / access_total > 100 ? 100 :
				(64'(miss_total) * 100) / access_total);
		end
		return r;
	endfunction

	function automatic access_t make_access(cmd_t c, logic [15:0] a, logic [7:0] d);
		access_t it;
		it.cmd = c;
		it.addr = a;
		it.data = d;
		return it;
	endfunction

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		logic [3:0]  hot_set;
		logic [15:0] a;
		int          roll;
		for (int i = 0; i < MEM_SIZE; i++)
			mem_image[i] = '0;
		for (int i = 0; i < LINES; i++) begin
			way_tag[i] = '0;
			way_valid[i] = 1'b0;
			way_dirty[i] = 1'b0;
			way_stamp[i] = '0;
		end
		stamp_count = '0;
		access_total = '0;
		miss_total = '0;
		stimulus_done = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// query with no accesses, field extremes, all ways of one set, eviction
		pending_items.push_back(make_access(CMD_QUERY, 16'hffff, 8'hff));
		pending_items.push_back(make_access(CMD_NONE, 16'h1234, 8'h5a));
		pending_items.push_back(make_access(CMD_READ, 16'h0000, 8'h00));
		pending_items.push_back(make_access(CMD_WRITE, 16'h0000, 8'hff));
		pending_items.push_back(make_access(CMD_READ, 16'h0000, 8'h00));
		pending_items.push_back(make_access(CMD_WRITE, 16'hffff, 8'h55));
		pending_items.push_back(make_access(CMD_READ, 16'hffff, 8'haa));
		for (int t = 1; t <= 4; t++)
			pending_items.push_back(make_access(CMD_WRITE, {6'(t), 4'd0, 6'(t)}, 8'(t*17)));
		pending_items.push_back(make_access(CMD_READ, 16'h0400, 8'h00));
		pending_items.push_back(make_access(CMD_READ, 16'h0000, 8'h00));
		pending_items.push_back(make_access(CMD_READ, {6'd2, 4'd0, 6'd2}, 8'h00));
		pending_items.push_back(make_access(CMD_QUERY, 16'h0000, 8'h00));
		pending_items.push_back(make_access(CMD_READ, 16'h0000, 8'h00));

		// random: mostly a few hot sets so hits, evictions and write-backs occur
		for (int n = 0; n < 700; n++) begin
			hot_set = 4'($urandom_range(0, 2));
			roll = $urandom_range(0, 99);
			if (roll < 70)
				a = {6'($urandom_range(0, 5)), hot_set, 6'($urandom)};
			else
				a = 16'($urandom);
			roll = $urandom_range(0, 99);
			pending_items.push_back(make_access(
				roll < 45 ? CMD_READ : roll < 90 ? CMD_WRITE :
				roll < 97 ? CMD_QUERY : CMD_NONE, a, 8'($urandom)));
			if (n == 250)
				wait (pending_items.size() < 20);
		end
		stimulus_done = 1'b1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= '0;
			address <= '0;
			write_data <= '0;
		end else if (!in_valid || !in_stall) begin
			if (pending_items.size() != 0 && (idle_free || $urandom_range(0, 99) >= 29)) begin
				access_t it;
				it = pending_items.pop_front();
				expected_answers.push_back(cache_access(it));
				in_valid <= 1'b1;
				command <= it.cmd;
				address <= it.addr;
				write_data <= it.data;
			end else
				in_valid <= 1'b0;
		end
	end

	// receiver stall pattern, with one long hold-off and one stretch with no idling
	int stall_phase;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			idle_free <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			idle_free <= stall_phase >= 80000 && stall_phase < 90000;
			if (stall_phase >= 70000 && stall_phase < 72000)
				out_stall <= 1'b1;
			else if (stall_phase >= 80000 && stall_phase < 90000)
				out_stall <= 1'b0;
			else
				out_stall <= $urandom_range(0, 99) < 29;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: result with none expected: rd=%h hit=%b rate=%0d",
					$time, read_data, was_hit, miss_rate_percent);
				failed = 1'b1;
			end else begin
				answer_t e;
				e = expected_answers.pop_front();
				if (e.rd !== read_data) begin
					$display("%0t: read_data expected %h actual %h", $time, e.rd, read_data);
					failed = 1'b1;
				end
				if (e.hit !== was_hit) begin
					$display("%0t: was_hit expected %b actual %b", $time, e.hit, was_hit);
					failed = 1'b1;
				end
				if (e.rate !== miss_rate_percent) begin
					$display("%0t: miss_rate_percent expected %0d actual %0d",
						$time, e.rate, miss_rate_percent);
					failed = 1'b1;
				end
			end
		end
	end

	// watchdog: the limit allows for the clearing pass after reset
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
	end

	initial begin
		failed = 1'b0;
		wait (arst_n === 1'b1);
		fork
			begin
				wait (stimulus_done && pending_items.size() == 0 && !in_valid &&
					expected_answers.size() == 0);
				repeat (300) @(posedge clk);
			end
			wait (watchdog >= WATCHDOG_LIMIT);
		join_any
		if (watchdog >= WATCHDOG_LIMIT || expected_answers.size() != 0 || failed)
			$display("write_back_lru_cache_top test failed");
		else
			$display("write_back_lru_cache_top test passed");
		$finish;
	end
endmodule
`default_nettype wire
